// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg - shared types for the sequence tag table
// Item types for both channels, the token that walks the slot chain,
// action codes and default sizes.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int unsigned TABLE_SLOTS_DEFAULT = 32;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned SEQ_W = 64;

	localparam logic ACTION_RECORD  = 1'b0;
	localparam logic ACTION_CONSUME = 1'b1;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] entry_key;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] sequence_number;
		logic             hit;
		logic             dropped;
	} out_item_t;

	// Request traveling down the chain, one cell per cycle.
	typedef struct packed {
		logic             active;
		logic             consume;
		logic             done;
		logic             hit;
		logic [KEY_W-1:0] key;
		logic [SEQ_W-1:0] seq;
	} token_t;

endpackage

// ===== hdl/stt_cell.sv =====
// ----------------------------------------------------------------------------
// stt_cell - one slot of the sequence tag table
// Holds one key, its sequence number and a valid bit. Serves the token that
// passes by and forwards it to the next cell on the following cycle.
// ----------------------------------------------------------------------------
module stt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::token_t tok_in,
	output stt_pkg::token_t tok_out
);

	logic [stt_pkg::KEY_W-1:0] key_q;
	logic [stt_pkg::SEQ_W-1:0] seq_q;
	logic                      valid_q;
	logic                      tok_active_q;
	stt_pkg::token_t           tok_pay_q;

	logic            pending;
	logic            do_store;
	logic            do_free;
	stt_pkg::token_t tok_next;

	assign pending  = tok_in.active && !tok_in.done;
	assign do_store = pending && !tok_in.consume && !valid_q;
	assign do_free  = pending && tok_in.consume && valid_q && (key_q == tok_in.key);

	always_comb begin
		tok_next = tok_in;
		if (do_store) begin
			tok_next.done = 1'b1;
		end
		if (do_free) begin
			tok_next.done = 1'b1;
			tok_next.hit  = 1'b1;
			tok_next.seq  = seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			tok_active_q <= 1'b0;
		end else begin
			tok_active_q <= tok_in.active;
			if (do_store) begin
				valid_q <= 1'b1;
			end else if (do_free) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_pay_q <= tok_next;
		if (do_store) begin
			key_q <= tok_in.key;
			seq_q <= tok_in.seq;
		end
	end

	always_comb begin
		tok_out        = tok_pay_q;
		tok_out.active = tok_active_q;
	end

endmodule

// ===== hdl/sequence_tag_table_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_tag_table_unit - associative table of keys tagged with sequence numbers
// Records with a nonzero key store it with the next sequence number in the
// lowest free slot; with tagging on, consumes take the lowest matching slot out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one item (action, entry_key).
//   Output channel out_valid/out_stall returns exactly one result per item.
//   Configuration channel cfg_valid/cfg_ready (always ready) sets tagging_enabled
//   from cfg_data. The user writes it only while the block is idle; not enforced.
// Operation:
//   An accepted item becomes a token that walks the row of slot cells, one
//   cell per cycle, lowest slot first. The first free cell takes a record,
//   the first matching valid cell answers a consume; later cells pass it on.
// Item flow:
//   The token passes through the cell registers in turn, and the result is
//   then registered in the output register. One item is in the row at a time:
//   a new item is not accepted until the previous token has left the row.
// Reset and stall:
//   Reset empties all slots, clears the counter and disables tagging.
//   A finished result waits in the output register; one more result can be
//   held in a skid register, and input is stalled while that one is full.
// ----------------------------------------------------------------------------
module sequence_tag_table_unit #(
	parameter int unsigned TABLE_SLOTS = stt_pkg::TABLE_SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stt_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	stt_pkg::token_t tok [TABLE_SLOTS+1];
	stt_pkg::token_t tok_entry;
	logic [TABLE_SLOTS-1:0] tok_active;

	logic                      tagging_enabled_q;
	logic [stt_pkg::SEQ_W-1:0] counter_q;
	logic                      busy_q;
	stt_pkg::out_item_t        out_q;
	logic                      out_valid_q;
	stt_pkg::out_item_t        skid_q;
	logic                      skid_valid_q;

	logic                      accept;
	logic [stt_pkg::SEQ_W-1:0] counter_inc;
	logic                      chain_end;
	logic                      take;
	stt_pkg::out_item_t        result;

	assign cfg_ready   = 1'b1;
	assign in_stall    = busy_q || skid_valid_q;
	assign accept      = in_valid && !in_stall;
	assign counter_inc = counter_q + 1'b1;

	// Entry token: items that need no table search are marked done here.
	always_comb begin
		tok_entry.active  = accept;
		tok_entry.consume = (in_data.action == stt_pkg::ACTION_CONSUME);
		tok_entry.key     = in_data.entry_key;
		tok_entry.hit     = 1'b0;
		if (in_data.action == stt_pkg::ACTION_CONSUME) begin
			tok_entry.seq  = '0;
			tok_entry.done = !tagging_enabled_q || (in_data.entry_key == '0);
		end else begin
			tok_entry.seq  = counter_inc;
			tok_entry.done = (in_data.entry_key == '0);
		end
	end

	assign tok[0] = tok_entry;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		stt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
		assign tok_active[i] = tok[i+1].active;
	end

	assign chain_end              = tok[TABLE_SLOTS].active;
	assign result.sequence_number = tok[TABLE_SLOTS].seq;
	assign result.hit             = tok[TABLE_SLOTS].hit;
	// A record that no cell took found the table full.
	assign result.dropped         = !tok[TABLE_SLOTS].consume && !tok[TABLE_SLOTS].done;
	assign take                   = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tagging_enabled_q <= 1'b0;
			counter_q         <= '0;
			busy_q            <= 1'b0;
			out_valid_q       <= 1'b0;
			skid_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tagging_enabled_q <= cfg_data;
			end
			if (accept && (in_data.action == stt_pkg::ACTION_RECORD)) begin
				counter_q <= counter_inc;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain_end) begin
				busy_q <= 1'b0;
			end
			if (!out_valid_q || take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= chain_end;
				end
			end else if (chain_end) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (chain_end) begin
				out_q <= result;
			end
		end else if (chain_end) begin
			skid_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// At most one request travels the cell row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_active))
		else $error("more than one token in the cell row");

	// The skid register is used only behind a held output.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output is empty");

	// A token leaving the row belongs to an item still in flight.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain_end |-> busy_q)
		else $error("token at row end without an item in flight");

	// New items enter only an empty row.
	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (tok_active == '0))
		else $error("item accepted while the row is occupied");

	// After a completed item, the output holds a valid result on the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		chain_end |=> out_valid_q)
		else $error("finished item produced no result");

endmodule

// ===== test/sequence_tag_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sequence_tag_table_unit_tb - self-checking bench for the sequence tag table
// Drives record and consume items with random gaps and output stalls, keeps
// a behavioral copy of the slot table and sequence counter, and checks each
// returned item field by field, in order, against the predicted one.
// ----------------------------------------------------------------------------
module sequence_tag_table_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_SLOTS = stt_pkg::TABLE_SLOTS_DEFAULT;
	localparam int KEY_POOL_SIZE = 16;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 5;
	localparam int MAX_PRINTED = 50;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	stt_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	stt_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;

	sequence_tag_table_unit #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow of the block's table
	logic [stt_pkg::KEY_W-1:0] slot_key [TABLE_SLOTS];
	logic [stt_pkg::SEQ_W-1:0] slot_seq [TABLE_SLOTS];
	logic                      slot_used [TABLE_SLOTS];
	logic [stt_pkg::SEQ_W-1:0] seq_count = '0;
	logic                      tagging_on = 1'b0;

	stt_pkg::in_item_t  pending_items [$];
	stt_pkg::out_item_t tags_due [$];
	logic [stt_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

	bit phase_enable [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	int phase_len [PHASES] = '{520, 160, 560, 160, 450};

	logic in_fire = 1'b0;
	int   idle_cycles = 0;
	int   error_count = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   long_left = 0;
	bit   hold_request = 1'b0;
	bit   hold_started = 1'b0;
	bit   quiet_tail = 1'b0;

	int n_records = 0;
	int n_consumes = 0;
	int n_hits = 0;
	int n_drops = 0;
	int n_checked = 0;
	int n_cfg_writes = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int s = 0; s < TABLE_SLOTS; s++) begin
			slot_used[s] = 1'b0;
			slot_key[s] = '0;
			slot_seq[s] = '0;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < MAX_PRINTED)
			$display("MISMATCH at %0d ns: %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Advance the shadow table by one item and return the item the block owes.
	function automatic stt_pkg::out_item_t tag_lookup_step(input stt_pkg::in_item_t item);
		stt_pkg::out_item_t res;
		int idx;
		int i;
		res = '0;
		idx = -1;
		if (item.action == stt_pkg::ACTION_RECORD) begin
			n_records++;
			seq_count = seq_count + 1'b1;
			res.sequence_number = seq_count;
			if (item.entry_key != '0) begin
				for (i = TABLE_SLOTS - 1; i >= 0; i--)
					if (!slot_used[i])
						idx = i;
				if (idx < 0) begin
					res.dropped = 1'b1;
					n_drops++;
				end else begin
					slot_used[idx] = 1'b1;
					slot_key[idx] = item.entry_key;
					slot_seq[idx] = seq_count;
				end
			end
		end else begin
			n_consumes++;
			// disabled tagging and key zero leave the table alone
			if (tagging_on && item.entry_key != '0) begin
				for (i = TABLE_SLOTS - 1; i >= 0; i--)
					if (slot_used[i] && slot_key[i] == item.entry_key)
						idx = i;
				if (idx >= 0) begin
					slot_used[idx] = 1'b0;
					res.sequence_number = slot_seq[idx];
					res.hit = 1'b1;
					n_hits++;
				end
			end
		end
		return res;
	endfunction

	// Input accept, register writes and result checking, all sampled at the edge.
	always @(posedge clk) begin
		stt_pkg::out_item_t want;
		bit progress;
		progress = 1'b0;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				tagging_on = cfg_data;
				n_cfg_writes++;
				progress = 1'b1;
			end
			if (in_valid && !in_stall) begin
				tags_due.push_back(tag_lookup_step(in_data));
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (tags_due.size() == 0) begin
					report_mismatch("result with nothing expected",
						out_data.sequence_number, '0);
				end else begin
					want = tags_due.pop_front();
					n_checked++;
					if (out_data.sequence_number !== want.sequence_number)
						report_mismatch("sequence_number", out_data.sequence_number,
							want.sequence_number);
					if (out_data.hit !== want.hit)
						report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
					if (out_data.dropped !== want.dropped)
						report_mismatch("dropped", 64'(out_data.dropped), 64'(want.dropped));
				end
			end
		end
		idle_cycles <= progress ? 0 : idle_cycles + 1;
	end

	// Sender: hold a stalled item, otherwise idle in bursts or offer the next one.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 17) - 1;
				in_valid <= 1'b0;
			end else begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver: one long hold-off on request, short stall bursts otherwise.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request && !hold_started) begin
				hold_started = 1'b1;
				long_left = LONG_HOLD;
			end
			if (long_left > 0) begin
				long_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic queue_item(input logic act, input logic [stt_pkg::KEY_W-1:0] key);
		stt_pkg::in_item_t item;
		item.action = act;
		item.entry_key = key;
		pending_items.push_back(item);
	endtask

	task automatic queue_segment(input int length, input int record_pct);
		logic act;
		logic [stt_pkg::KEY_W-1:0] key;
		int k;
		repeat (length) begin
			act = ($urandom_range(1, 100) <= record_pct) ? stt_pkg::ACTION_RECORD
				: stt_pkg::ACTION_CONSUME;
			k = $urandom_range(0, 99);
			if (k < 70)
				key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
			else if (k < 78)
				key = '0;
			else if (k < 82)
				key = '1;
			else
				key = {$urandom, $urandom};
			queue_item(act, key);
		end
	endtask

	// Wait until nothing is queued, offered or owed by the block.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || tags_due.size() != 0);
	endtask

	task automatic write_tagging(input logic value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int left;
		int seg;
		int pct;
		bit first;
		for (int p = 0; p < KEY_POOL_SIZE; p++) begin
			key_pool[p] = {$urandom, $urandom};
			if (key_pool[p] == '0)
				key_pool[p] = 64'd1;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tagging off: records still count and store, consumes return nothing
		write_tagging(1'b0);
		queue_item(stt_pkg::ACTION_RECORD, '1);
		queue_item(stt_pkg::ACTION_RECORD, '0);
		queue_item(stt_pkg::ACTION_CONSUME, '1);
		queue_item(stt_pkg::ACTION_CONSUME, '0);
		queue_item(stt_pkg::ACTION_RECORD, 64'h1);
		queue_item(stt_pkg::ACTION_RECORD, 64'h8000_0000_0000_0000);
		wait_idle();

		// tagging on: hits, misses, key zero and duplicate keys
		write_tagging(1'b1);
		queue_item(stt_pkg::ACTION_CONSUME, '1);
		queue_item(stt_pkg::ACTION_CONSUME, '1);
		queue_item(stt_pkg::ACTION_CONSUME, '0);
		queue_item(stt_pkg::ACTION_RECORD, 64'hA5A5_5A5A_A5A5_5A5A);
		queue_item(stt_pkg::ACTION_RECORD, 64'hA5A5_5A5A_A5A5_5A5A);
		queue_item(stt_pkg::ACTION_CONSUME, 64'hA5A5_5A5A_A5A5_5A5A);
		queue_item(stt_pkg::ACTION_CONSUME, 64'hA5A5_5A5A_A5A5_5A5A);
		queue_item(stt_pkg::ACTION_CONSUME, 64'h1);
		queue_item(stt_pkg::ACTION_CONSUME, 64'h8000_0000_0000_0000);
		queue_item(stt_pkg::ACTION_CONSUME, 64'h5A5A_A5A5_5A5A_A5A5);
		queue_item(stt_pkg::ACTION_CONSUME, 64'h1);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			if (ph == 2)
				hold_request = 1'b1;
			if (ph == PHASES - 1)
				quiet_tail = 1'b1;
			write_tagging(phase_enable[ph]);
			left = phase_len[ph];
			first = 1'b1;
			while (left > 0) begin
				// open each phase with a run of records that overflows the table
				seg = first ? TABLE_SLOTS + 8 : $urandom_range(8, 60);
				if (seg > left)
					seg = left;
				case (first ? 4 : $urandom_range(0, 4))
					0: pct = 20;
					1: pct = 50;
					2: pct = 80;
					3: pct = 0;
					default: pct = 100;
				endcase
				queue_segment(seg, pct);
				left -= seg;
				first = 1'b0;
			end
		end

		wait_idle();
		repeat (TABLE_SLOTS + 10) @(posedge clk);
		if (tags_due.size() != 0)
			report_mismatch("results never delivered", 64'(tags_due.size()), '0);
		$display("Covered %0d items: %0d records (%0d dropped on a full table), %0d consumes",
			n_checked, n_records, n_drops, n_consumes);
		$display("%0d consumes hit, %0d register writes, one long output hold-off",
			n_hits, n_cfg_writes);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sequence_tag_table_unit.f =====
hdl/stt_pkg.sv
hdl/stt_cell.sv
hdl/sequence_tag_table_unit.sv
test/sequence_tag_table_unit_tb.sv
